### hw/rtl/dlc_pkg.sv
// Shared constants and types for the direct linear convolution block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dlc_pkg;

	// kernel depth and sample format
	localparam int MAX_TAPS    = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int OUT_W       = 37;
	localparam int CNT_W       = $clog2(MAX_TAPS + 1);
	localparam int IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	// item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]       acc_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;    // take neighbour sum into the accumulator
		logic clear;    // zero the accumulator
		logic tap_we;   // write the tap register
		logic tap_vld;  // tap lies below the loaded count
	} cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/dlc_in_if.sv
// Input channel: command, value and last flag under a valid/ready handshake.
// Depends on dlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dlc_in_if import dlc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    command;
	sample_t value;
	logic    last;

	modport source (output valid, output command, output value, output last, input ready);
	modport sink   (input valid, input command, input value, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/dlc_out_if.sv
// Result channel: one convolution output and its end flag per beat.
// Depends on dlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dlc_out_if import dlc_pkg::*; ();
	logic valid;
	logic ready;
	acc_t result_value;
	logic result_last;

	modport source (output valid, output result_value, output result_last, input ready);
	modport sink   (input valid, input result_value, input result_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/dlc_cell.sv
// One transposed-form cell: a tap, its product with the broadcast sample and
// one partial-sum register fed by the next cell up. Depends on dlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlc_cell import dlc_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire sample_t    tap_in,
	input  wire sample_t    x,
	input  wire acc_t       sum_in,
	output acc_t            sum_out
);

	sample_t                  tap_q;
	acc_t                     acc_q;
	logic signed [PROD_W-1:0] prod;
	acc_t                     term;

	// tap store, no reset: only read once valid
	always_ff @(posedge clk) begin
		if (ctl.tap_we) begin
			tap_q <= tap_in;
		end
	end

	// product, dropped for taps not yet loaded
	always_comb begin
		prod = tap_q * x;
		term = ctl.tap_vld ? acc_t'({{(OUT_W-PROD_W){prod[PROD_W-1]}}, prod}) : '0;
	end

	assign sum_out = acc_q + term;

	// partial sum moves one cell down on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= sum_in;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/direct_linear_convolution.sv
// Top level of the direct linear convolution: kernel loader, flush sequencer,
// the row of dlc_cell and the result register. Depends on dlc_pkg, the interfaces.
//
//   channel  dir  payload                         beat when
//   item     in   command, value[15:0], last      item.valid && item.ready
//   result   out  result_value[36:0], result_last result.valid && result.ready
//
// A tap load or a data sample is taken every cycle unless held off; a sample leaves
// its result in the output register the cycle after, as the next item is taken.
// A last sample with m taps is followed by m-1 flush beats, one per unstalled cycle,
// during which the item channel is held off; the row shifts itself clear meanwhile.
// A stalled result holds the whole row (item.ready follows result.ready).
// Reset clears counts, sums, flush and valid flags, sets closed_q; taps need no reset.
`timescale 1ns / 1ps
`default_nettype none

module direct_linear_convolution import dlc_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	dlc_in_if.sink    item,
	dlc_out_if.source result
);

	logic [CNT_W-1:0] count_q;
	logic             closed_q;
	logic             flush_q;
	logic [IDX_W-1:0] flush_cnt_q;
	logic             res_valid_q;
	acc_t             res_value_q;
	logic             res_last_q;

	logic             adv;
	logic             acc_item;
	logic             load_acc;
	logic             push_acc;
	logic             shift;
	logic [CNT_W-1:0] load_idx;
	logic             tap_write;
	sample_t          x;
	cell_ctl_t        ctl [MAX_TAPS];
	acc_t             sums [MAX_TAPS+1];

	// handshake and broadcast sample
	assign adv       = !res_valid_q || result.ready;
	assign item.ready = !flush_q && adv;
	assign acc_item  = item.valid && item.ready;
	assign load_acc  = acc_item && (item.command == CMD_LOAD);
	assign push_acc  = acc_item && (item.command == CMD_PUSH);
	assign shift     = push_acc || (flush_q && adv);
	assign x         = flush_q ? sample_t'(0) : item.value;

	// tap slot: a load after a closed kernel starts again at zero
	assign load_idx  = closed_q ? '0 : count_q;
	assign tap_write = load_acc && (load_idx < CNT_W'(MAX_TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b1;
		end else if (load_acc) begin
			count_q  <= tap_write ? load_idx + CNT_W'(1) : load_idx;
			closed_q <= item.last;
		end
	end

	// flush sequencer for the trailing outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q     <= 1'b0;
			flush_cnt_q <= '0;
		end else if (push_acc && item.last && (count_q > CNT_W'(1))) begin
			flush_q     <= 1'b1;
			flush_cnt_q <= IDX_W'(count_q - CNT_W'(1));
		end else if (flush_q && adv) begin
			flush_q     <= (flush_cnt_q != IDX_W'(1));
			flush_cnt_q <= flush_cnt_q - IDX_W'(1);
		end
	end

	// cell row
	assign sums[MAX_TAPS] = '0;

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		always_comb begin
			ctl[j].shift   = shift;
			ctl[j].clear   = load_acc && closed_q;
			ctl[j].tap_we  = tap_write && (load_idx[IDX_W-1:0] == IDX_W'(j));
			ctl[j].tap_vld = (CNT_W'(j) < count_q);
		end

		dlc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[j]),
			.tap_in  (item.value),
			.x       (x),
			.sum_in  (sums[j+1]),
			.sum_out (sums[j])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (shift) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			res_value_q <= sums[0];
			res_last_q  <= flush_q ? (flush_cnt_q == IDX_W'(1))
			                       : (item.last && (count_q <= CNT_W'(1)));
		end
	end

	assign result.valid        = res_valid_q;
	assign result.result_value = res_value_q;
	assign result.result_last  = res_last_q;

	// checks
	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(push_acc && item.last && (count_q > CNT_W'(1))) |=> flush_q)
		else $error("flush did not start after last sample");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && adv && (flush_cnt_q == IDX_W'(1)))
		|=> (!flush_q && result.valid && result.result_last))
		else $error("flush end not flagged");

	a_empty_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		(push_acc && (count_q == '0)) |=> (result.valid && (result.result_value == '0)))
		else $error("empty kernel gave a non-zero output");

endmodule

`default_nettype wire
